// ----- rtl/rhc_pkg.sv -----
`default_nettype none

package rhc_pkg;

    // pixel component width
    localparam int COMP_W = 8;

    // widths of the divider operands (numerator never exceeds denominator)
    localparam int SUM_W = COMP_W + 1;          // max + min
    localparam int HUE_W = COMP_W + 3;          // 6 * d, up to 1530

    // lightness divides max + min by twice the full-scale component
    localparam logic [SUM_W-1:0] LIG_DEN = SUM_W'(510);

    // full-scale component value
    localparam logic [SUM_W-1:0] COMP_FULL = SUM_W'(255);

    // sector of the hue, picked in priority red, green, blue
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } t_sector;

endpackage

`default_nettype wire

// ----- rtl/rhc_div.sv -----
`default_nettype none

// pipelined restoring divider, one quotient bit per stage
// quotient = floor(num * 2^(QB-1) / den), valid for num <= den
module rhc_div #(
    parameter int W  = 9,
    parameter int QB = 17
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [W-1:0]  i_num,
    input  wire logic [W-1:0]  i_den,
    output logic      [QB-1:0] o_quo
);

    logic [W-1:0]  r_rem [QB];
    logic [W-1:0]  r_den [QB];
    logic [QB-1:0] r_quo [QB];

    logic [W-1:0]  n_rem [QB];
    logic [W-1:0]  n_den [QB];
    logic [QB-1:0] n_quo [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        logic [W:0]    w_part;
        logic [W:0]    w_diff;
        logic          w_ge;
        logic [W-1:0]  w_den_in;
        logic [QB-1:0] w_quo_in;

        if (k == 0) begin : g_first
            assign w_part   = {1'b0, i_num};
            assign w_den_in = i_den;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_part   = {r_rem[k-1], 1'b0};
            assign w_den_in = r_den[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        always_comb begin
            n_den[k] = w_den_in;
            n_quo[k] = w_quo_in;
            w_ge     = (w_part >= {1'b0, n_den[k]});
            w_diff   = w_part - {1'b0, n_den[k]};
            n_rem[k] = w_ge ? w_diff[W-1:0] : w_part[W-1:0];
            n_quo[k][QB-1-k] = w_ge;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= n_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[QB-1];

endmodule

`default_nettype wire

// ----- rtl/rgb_to_hsl_converter_unit.sv -----
`default_nettype none

// channel    | direction | tdata fields (lowest bit up)           | tuser / tlast
// s_axis     | in        | red[7:0], green[7:0], blue[7:0]        | none
// m_axis     | out       | hue, saturation, lightness (OUT_BITS)  | none
//
// one pixel per clock while the output is taken; the path is an input
// register, two stages of min/max and hue setup, OUT_BITS + 1 divider stages
// (one quotient bit each, lightness rides beside them) and the output register
// reset clears only the valid bits; payload registers are not reset
// one enable moves the whole pipeline: it holds while the output register is
// full and not taken, so a stall drops or repeats no transaction
module rgb_to_hsl_converter_unit #(
    parameter int OUT_BITS = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // slave side
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [23:0]            i_s_axis_tdata,   // red, green, blue
    // master side
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [((3*OUT_BITS+7)/8)*8-1:0] o_m_axis_tdata // hue, saturation, lightness, pad
);

    localparam int QB    = OUT_BITS + 1;                 // quotient incl. the "one" bit
    localparam int OUT_W = ((3 * OUT_BITS + 7) / 8) * 8;
    localparam int CW    = rhc_pkg::COMP_W;
    localparam int SW    = rhc_pkg::SUM_W;
    localparam int HW    = rhc_pkg::HUE_W;
    localparam int LREP  = (OUT_BITS + 7) / 8;           // copies of the remainder byte

    // pipeline advance
    logic w_en;
    logic r_out_valid;

    assign w_en            = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // stage 0: input register
    logic          r_v0;
    logic [CW-1:0] r0_red, r0_green, r0_blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r0_red   <= i_s_axis_tdata[CW-1:0];
            r0_green <= i_s_axis_tdata[2*CW-1:CW];
            r0_blue  <= i_s_axis_tdata[3*CW-1:2*CW];
        end
    end

    // stage 1: max, min, sector and signed component difference
    logic [CW-1:0]      w_mx, w_mn;
    rhc_pkg::t_sector   n1_sec;
    logic signed [CW:0] n1_diff;

    always_comb begin
        w_mx = r0_red;
        w_mn = r0_red;
        if (r0_green > w_mx) w_mx = r0_green;
        if (r0_blue  > w_mx) w_mx = r0_blue;
        if (r0_green < w_mn) w_mn = r0_green;
        if (r0_blue  < w_mn) w_mn = r0_blue;

        // first component equal to the max wins
        if (w_mx == r0_red) begin
            n1_sec  = rhc_pkg::SEC_RED;
            n1_diff = $signed({1'b0, r0_green}) - $signed({1'b0, r0_blue});
        end else if (w_mx == r0_green) begin
            n1_sec  = rhc_pkg::SEC_GREEN;
            n1_diff = $signed({1'b0, r0_blue}) - $signed({1'b0, r0_red});
        end else begin
            n1_sec  = rhc_pkg::SEC_BLUE;
            n1_diff = $signed({1'b0, r0_red}) - $signed({1'b0, r0_green});
        end
    end

    logic               r_v1;
    logic [SW-1:0]      r1_sum;
    logic [CW-1:0]      r1_d;
    rhc_pkg::t_sector   r1_sec;
    logic signed [CW:0] r1_diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_sum  <= {1'b0, w_mx} + {1'b0, w_mn};
            r1_d    <= w_mx - w_mn;
            r1_sec  <= n1_sec;
            r1_diff <= n1_diff;
        end
    end

    // stage 2: hue numerator (2 * sector * d + diff, plus 6 * d on a red wrap), hue and saturation denominators
    logic [HW-1:0] w_d6;
    logic [HW-1:0] w_base;
    logic [HW:0]   w_hnum;
    logic [SW-1:0] w_sden;

    always_comb begin
        w_d6 = HW'({r1_d, 2'b00}) + HW'({r1_d, 1'b0});
        case (r1_sec)
            rhc_pkg::SEC_RED:   w_base = r1_diff[CW] ? w_d6 : '0;   // wrap when green < blue
            rhc_pkg::SEC_GREEN: w_base = HW'({r1_d, 1'b0});
            rhc_pkg::SEC_BLUE:  w_base = HW'({r1_d, 2'b00});
            default:            w_base = '0;
        endcase
        w_hnum = {1'b0, w_base} + {{(HW-CW){r1_diff[CW]}}, r1_diff};
        // upper half of the lightness range measures against 510 - sum
        w_sden = r1_sum[SW-1] ? (rhc_pkg::LIG_DEN - r1_sum) : r1_sum;
    end

    logic          r_v2;
    logic          r2_ach;
    logic [HW-1:0] r2_hnum, r2_hden;
    logic [SW-1:0] r2_snum, r2_sden, r2_lnum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_ach  <= (r1_d == '0);
            r2_hnum <= w_hnum[HW-1:0];
            r2_hden <= w_d6;
            r2_snum <= SW'(r1_d);
            r2_sden <= w_sden;
            r2_lnum <= r1_sum;
        end
    end

    // divider stages, one quotient bit per stage, two lanes in lockstep
    logic [QB-1:0] w_hq, w_sq;

    rhc_div #(.W(HW), .QB(QB)) u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_hnum),
        .i_den (r2_hden),
        .o_quo (w_hq)
    );

    rhc_div #(.W(SW), .QB(QB)) u_div_sat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r2_snum),
        .i_den (r2_sden),
        .o_quo (w_sq)
    );

    // valid and achromatic flag travel beside the divider stages
    logic [QB-1:0] r_vd;
    logic [QB-1:0] r_achd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd <= '0;
        end else if (w_en) begin
            r_vd <= {r_vd[QB-2:0], r_v2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_achd <= {r_achd[QB-2:0], r2_ach};
        end
    end

    // max + min travels beside the divider stages for the lightness
    logic [SW-1:0] r_lsum [QB];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lsum[0] <= r2_lnum;
            for (int k = 1; k < QB; k++) begin
                r_lsum[k] <= r_lsum[k-1];
            end
        end
    end

    // output register: clamp a full-scale quotient, zero hue and saturation
    // for gray pixels (their hue lane ran on a zero denominator)
    logic [OUT_BITS-1:0] w_hue, w_sat, w_lig;
    logic [OUT_BITS-1:0] r_out_hue, r_out_sat, r_out_lig;
    logic [SW-1:0]       w_lsum;
    logic                w_lhalf;
    logic [CW-1:0]       w_lrem;
    logic [CW*LREP-1:0]  w_lrep;

    assign w_hue = w_hq[QB-1] ? '1 : w_hq[OUT_BITS-1:0];
    assign w_sat = w_sq[QB-1] ? '1 : w_sq[OUT_BITS-1:0];

    // lightness = sum / 510: split sum = 255 * q + rem, then rem / 255 in
    // binary is the byte rem repeated; q is the integer bit
    // white (sum 510) gives rem 255, all ones, which is the clamped code
    always_comb begin
        w_lsum  = r_lsum[QB-1];
        w_lhalf = (w_lsum >= rhc_pkg::COMP_FULL);
        w_lrem  = w_lhalf ? CW'(w_lsum - rhc_pkg::COMP_FULL) : w_lsum[CW-1:0];
        w_lrep  = {LREP{w_lrem}};
        w_lig   = {w_lhalf, w_lrep[CW*LREP-1 -: OUT_BITS-1]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_vd[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_hue <= r_achd[QB-1] ? '0 : w_hue;
            r_out_sat <= r_achd[QB-1] ? '0 : w_sat;
            r_out_lig <= w_lig;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_W'({r_out_lig, r_out_sat, r_out_hue});

    // a colored pixel always has nonzero saturation
    a_hue_needs_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_hue != '0) |-> (r_out_sat != '0))
        else $error("hue without saturation");

    // a held pipeline keeps its in-flight transactions
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> ($stable(r_vd) && $stable(r_out_lig)))
        else $error("pipeline moved while stalled");

    // a saturated-gray result is impossible: gray means zero saturation
    a_gray_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_vd[QB-1] && r_achd[QB-1]) |=> (r_out_sat == '0 && r_out_hue == '0))
        else $error("gray pixel with color");

endmodule

`default_nettype wire
